// ===== rtl/tkfp_pkg.sv =====
// Shared types and constants for the three-kind frame parser.
package tkfp_pkg;

	// Number of bytes in a command frame.
	localparam int CMD_LEN = 8;
	localparam int CMD_CNT_W = $clog2(CMD_LEN + 1);
	localparam logic [CMD_CNT_W-1:0] CMD_LEN_C = CMD_CNT_W'(CMD_LEN);
	localparam logic [CMD_CNT_W-1:0] CMD_LAST_C = CMD_CNT_W'(CMD_LEN - 1);

	// Configuration register indexes.
	localparam logic [1:0] CFG_DATA_ID = 2'd0;
	localparam logic [1:0] CFG_WB_ID = 2'd1;
	localparam logic [1:0] CFG_CMD_ID = 2'd2;

	// event_kind codes.
	localparam logic [1:0] EV_DATA = 2'd0;
	localparam logic [1:0] EV_WB = 2'd1;
	localparam logic [1:0] EV_CMD = 2'd2;
	localparam logic [1:0] EV_ERROR = 2'd3;

	// aborted_kind codes.
	localparam logic [1:0] AB_DATA = 2'd0;
	localparam logic [1:0] AB_WB = 2'd1;
	localparam logic [1:0] AB_CMD = 2'd2;

	// Sub-phase values inside the data and writeback frames.
	localparam logic [2:0] PH_HDR0 = 3'd0;
	localparam logic [2:0] PH_HDR1 = 3'd1;
	localparam logic [2:0] PH_CNT_HI = 3'd2;
	localparam logic [2:0] PH_CNT_LO = 3'd3;
	localparam logic [2:0] PH_BODY = 3'd4;

	typedef enum logic [1:0] {
		FRAME_IDLE = 2'd0,
		FRAME_DATA = 2'd1,
		FRAME_WB = 2'd2,
		FRAME_CMD = 2'd3
	} frame_kind_t;

	// Decoded action for the byte in the input register.
	typedef struct packed {
		logic abort;
		logic data_grp;
		logic data_last;
		logic wb_req;
		logic cmd_beat;
		logic cmd_last;
		logic start;
	} action_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [15:0] group_index;
		logic [15:0] first_half;
		logic [15:0] second_half;
		logic is_last;
		logic [5:0] cmd_index;
		logic [7:0] cmd_byte;
		logic [15:0] resend_times;
		logic start_output;
		logic [1:0] aborted_kind;
	} result_t;

endpackage

// ===== rtl/three_kind_frame_parser.sv =====
// Top level of the three-kind frame parser: byte-serial frame decoder.
//
// Usage:
//   Input channel (in_valid / in_stall / rx_byte) carries one received byte
//   per beat. Output channel (out_valid / out_stall / result fields) carries
//   at most one result beat per input byte: a data group (two 16-bit halves),
//   a writeback request, a command byte, or a protocol error.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) sets the
//   three frame-ID bytes; cfg_ready is always high. Write only while idle.
// Timing:
//   A byte is held in the input register, then its result is loaded
//   into the output register. One byte per cycle sustained while no result
//   is held by out_stall; the single decode stage between the input
//   register and the output register sets that figure.
// Reset:
//   arst_n clears both pipeline valids and the parser state and sets the
//   frame IDs (data 1, writeback 2, command 3).
// Stall:
//   While out_stall holds a result, the input register still drains bytes
//   that make no result; a byte that makes a result waits, and in_stall
//   rises only then.
module three_kind_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [15:0] group_index,
	output logic [15:0] first_half,
	output logic [15:0] second_half,
	output logic        is_last,
	output logic [5:0]  cmd_index,
	output logic [7:0]  cmd_byte,
	output logic [15:0] resend_times,
	output logic        start_output,
	output logic [1:0]  aborted_kind,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	// config registers
	logic [7:0] data_id_q, wb_id_q, cmd_id_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parser state
	tkfp_pkg::frame_kind_t frame_q, frame_d;
	logic [2:0]  phase_q, phase_d;
	logic [15:0] target_q, target_d;
	logic [17:0] rcvd_q, rcvd_d;
	logic [23:0] partial_q, partial_d;
	logic        running_q, running_d;
	logic [tkfp_pkg::CMD_CNT_W-1:0] cmd_cnt_q, cmd_cnt_d;
	logic [7:0]  rs_hi_q, rs_hi_d, rs_lo_q, rs_lo_d;

	// result register
	logic              out_valid_q;
	tkfp_pkg::result_t res_d, res_q;
	logic              res_valid;

	tkfp_pkg::action_t act;
	logic [15:0] groups;
	logic [1:0]  pos;
	logic [7:0]  rs_lo_now;
	logic        advance;
	logic        accept;

	assign groups = rcvd_q[17:2];
	assign pos = rcvd_q[1:0];

	// A byte leaves the input register unless it would overwrite a held result.
	assign advance = valid_s1 && (!out_valid_q || !out_stall || !res_valid);
	assign in_stall = valid_s1 && !advance;
	assign accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Config writes; index 3 is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_id_q <= 8'd1;
			wb_id_q <= 8'd2;
			cmd_id_q <= 8'd3;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tkfp_pkg::CFG_DATA_ID: data_id_q <= cfg_data;
				tkfp_pkg::CFG_WB_ID:   wb_id_q <= cfg_data;
				tkfp_pkg::CFG_CMD_ID:  cmd_id_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

	// Decode what the current byte does.
	always_comb begin
		act = '0;
		unique case (frame_q)
			tkfp_pkg::FRAME_DATA: begin
				if (phase_q == tkfp_pkg::PH_HDR0 || phase_q == tkfp_pkg::PH_HDR1) begin
					act.abort = (byte_s1 != 8'd0);
				end else if (phase_q > tkfp_pkg::PH_BODY) begin
					act.abort = 1'b1;
				end else if (phase_q == tkfp_pkg::PH_BODY) begin
					act.data_grp = (groups < target_q) && (pos == 2'd3);
				end
			end
			tkfp_pkg::FRAME_WB: begin
				if (phase_q == tkfp_pkg::PH_HDR0 || phase_q == tkfp_pkg::PH_HDR1) begin
					act.abort = (byte_s1 != 8'd0);
				end else if (phase_q > tkfp_pkg::PH_CNT_LO) begin
					act.abort = 1'b1;
				end else begin
					act.wb_req = (phase_q == tkfp_pkg::PH_CNT_HI);
				end
			end
			tkfp_pkg::FRAME_CMD: begin
				if (cmd_cnt_q >= tkfp_pkg::CMD_LEN_C) begin
					act.abort = 1'b1;
				end else begin
					act.cmd_beat = 1'b1;
				end
			end
			default: ;
		endcase
		act.data_last = act.data_grp && ({1'b0, groups} + 17'd1 == {1'b0, target_q});
		act.cmd_last = act.cmd_beat && (cmd_cnt_q == tkfp_pkg::CMD_LAST_C);
		act.start = act.cmd_last && !running_q && (groups != 16'd0);
	end

	// The second command byte is the current one while cmd_cnt_q is 1.
	assign rs_lo_now = (cmd_cnt_q == tkfp_pkg::CMD_CNT_W'(1)) ? byte_s1 : rs_lo_q;

	// Next state.
	always_comb begin
		frame_d = frame_q;
		phase_d = phase_q;
		target_d = target_q;
		rcvd_d = rcvd_q;
		partial_d = partial_q;
		running_d = running_q;
		cmd_cnt_d = cmd_cnt_q;
		rs_hi_d = rs_hi_q;
		rs_lo_d = rs_lo_q;
		unique case (frame_q)
			tkfp_pkg::FRAME_IDLE: begin
				if (byte_s1 == data_id_q) begin
					frame_d = tkfp_pkg::FRAME_DATA;
					phase_d = tkfp_pkg::PH_HDR0;
					target_d = '0;
					rcvd_d = '0;
					partial_d = '0;
					running_d = 1'b0;
				end else if (byte_s1 == wb_id_q) begin
					frame_d = tkfp_pkg::FRAME_WB;
					phase_d = tkfp_pkg::PH_HDR0;
				end else if (byte_s1 == cmd_id_q) begin
					frame_d = tkfp_pkg::FRAME_CMD;
					phase_d = tkfp_pkg::PH_HDR0;
					cmd_cnt_d = '0;
					rs_hi_d = '0;
					rs_lo_d = '0;
				end
			end
			tkfp_pkg::FRAME_DATA: begin
				if (act.abort) begin
					frame_d = tkfp_pkg::FRAME_IDLE;
					target_d = '0;
					rcvd_d = '0;
					partial_d = '0;
					running_d = 1'b0;
				end else if (phase_q == tkfp_pkg::PH_CNT_HI) begin
					target_d = {byte_s1, 8'd0};
					phase_d = tkfp_pkg::PH_CNT_LO;
				end else if (phase_q == tkfp_pkg::PH_CNT_LO) begin
					target_d = {target_q[15:8], byte_s1};
					phase_d = tkfp_pkg::PH_BODY;
				end else if (phase_q == tkfp_pkg::PH_BODY) begin
					if (groups < target_q) begin
						rcvd_d = rcvd_q + 18'd1;
						partial_d = act.data_grp ? 24'd0 : {partial_q[15:0], byte_s1};
						if (act.data_last) begin
							frame_d = tkfp_pkg::FRAME_IDLE;
						end
					end
				end else begin
					phase_d = phase_q + 3'd1;
				end
			end
			tkfp_pkg::FRAME_WB: begin
				if (act.abort || phase_q == tkfp_pkg::PH_CNT_LO) begin
					frame_d = tkfp_pkg::FRAME_IDLE;
				end else begin
					phase_d = phase_q + 3'd1;
				end
			end
			tkfp_pkg::FRAME_CMD: begin
				if (act.abort) begin
					frame_d = tkfp_pkg::FRAME_IDLE;
					cmd_cnt_d = '0;
					rs_hi_d = '0;
					rs_lo_d = '0;
				end else begin
					if (cmd_cnt_q == '0) begin
						rs_hi_d = byte_s1;
					end
					rs_lo_d = rs_lo_now;
					cmd_cnt_d = cmd_cnt_q + tkfp_pkg::CMD_CNT_W'(1);
					if (act.cmd_last) begin
						frame_d = tkfp_pkg::FRAME_IDLE;
					end
					if (act.start) begin
						running_d = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// Result fields; fields outside the event kind stay zero.
	always_comb begin
		res_d = '0;
		res_valid = act.abort || act.data_grp || act.wb_req || act.cmd_beat;
		if (act.abort) begin
			res_d.event_kind = tkfp_pkg::EV_ERROR;
			unique case (frame_q)
				tkfp_pkg::FRAME_DATA: res_d.aborted_kind = tkfp_pkg::AB_DATA;
				tkfp_pkg::FRAME_WB:   res_d.aborted_kind = tkfp_pkg::AB_WB;
				default:              res_d.aborted_kind = tkfp_pkg::AB_CMD;
			endcase
		end else if (act.data_grp) begin
			res_d.event_kind = tkfp_pkg::EV_DATA;
			res_d.group_index = groups;
			res_d.first_half = partial_q[23:8];
			res_d.second_half = {partial_q[7:0], byte_s1};
			res_d.is_last = act.data_last;
		end else if (act.wb_req) begin
			res_d.event_kind = tkfp_pkg::EV_WB;
			res_d.group_index = groups;
		end else if (act.cmd_beat) begin
			res_d.event_kind = tkfp_pkg::EV_CMD;
			res_d.cmd_index = 6'(cmd_cnt_q);
			res_d.cmd_byte = byte_s1;
			res_d.is_last = act.cmd_last;
			res_d.resend_times = act.cmd_last ? {rs_hi_q, rs_lo_now} : 16'd0;
			res_d.start_output = act.start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= tkfp_pkg::FRAME_IDLE;
			phase_q <= '0;
			target_q <= '0;
			rcvd_q <= '0;
			partial_q <= '0;
			running_q <= 1'b0;
			cmd_cnt_q <= '0;
			rs_hi_q <= '0;
			rs_lo_q <= '0;
		end else if (advance) begin
			frame_q <= frame_d;
			phase_q <= phase_d;
			target_q <= target_d;
			rcvd_q <= rcvd_d;
			partial_q <= partial_d;
			running_q <= running_d;
			cmd_cnt_q <= cmd_cnt_d;
			rs_hi_q <= rs_hi_d;
			rs_lo_q <= rs_lo_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign event_kind = res_q.event_kind;
	assign group_index = res_q.group_index;
	assign first_half = res_q.first_half;
	assign second_half = res_q.second_half;
	assign is_last = res_q.is_last;
	assign cmd_index = res_q.cmd_index;
	assign cmd_byte = res_q.cmd_byte;
	assign resend_times = res_q.resend_times;
	assign start_output = res_q.start_output;
	assign aborted_kind = res_q.aborted_kind;

endmodule

// ===== rtl/tkfp_checker.sv =====
// Port-level assertions for the three-kind frame parser, with bind.
module tkfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  event_kind,
	input logic [15:0] group_index,
	input logic [15:0] first_half,
	input logic [15:0] second_half,
	input logic        is_last,
	input logic [15:0] resend_times,
	input logic        start_output
);

	// Held result beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_kind) &&
		$stable(group_index) && $stable(first_half) && $stable(second_half))
		else $error("result changed while stalled");

	// Input backs up only behind a stalled output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without output back-pressure");

	// Last mark only on data groups and command bytes.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_last |->
		event_kind == tkfp_pkg::EV_DATA || event_kind == tkfp_pkg::EV_CMD)
		else $error("is_last on wrong event kind");

	// Output start only on the last command byte.
	a_start_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_output |-> is_last && event_kind == tkfp_pkg::EV_CMD)
		else $error("start_output outside last command byte");

	// Resend count only on the last command byte.
	a_resend_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && resend_times != 16'd0 |-> is_last && event_kind == tkfp_pkg::EV_CMD)
		else $error("resend_times outside last command byte");

endmodule

bind three_kind_frame_parser tkfp_checker u_tkfp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.event_kind(event_kind),
	.group_index(group_index),
	.first_half(first_half),
	.second_half(second_half),
	.is_last(is_last),
	.resend_times(resend_times),
	.start_output(start_output)
);

// ===== tb/three_kind_frame_parser_tb.sv =====
// Self-checking testbench for the three-kind frame parser.
`timescale 1ns / 1ps

module three_kind_frame_parser_tb;
	import tkfp_pkg::*;

	// Tracks the parser state byte by byte and queues the result beats each
	// accepted byte should produce; result beats are checked against the queue.
	class frame_event_model;
		logic [7:0] id_data;
		logic [7:0] id_wb;
		logic [7:0] id_cmd;
		frame_kind_t kind;
		logic [2:0] phase;
		logic [15:0] target;
		logic [17:0] rcvd;
		logic [23:0] partial;
		bit running;
		logic [CMD_CNT_W-1:0] cmd_cnt;
		logic [7:0] rs_hi;
		logic [7:0] rs_lo;
		result_t pending_events[$];
		bit failed;

		function new();
			id_data = 8'd1;
			id_wb = 8'd2;
			id_cmd = 8'd3;
			kind = FRAME_IDLE;
			phase = PH_HDR0;
			target = '0;
			rcvd = '0;
			partial = '0;
			running = 1'b0;
			cmd_cnt = '0;
			rs_hi = '0;
			rs_lo = '0;
			failed = 1'b0;
		endfunction

		function void set_id(logic [1:0] idx, logic [7:0] val);
			case (idx)
				CFG_DATA_ID: id_data = val;
				CFG_WB_ID: id_wb = val;
				CFG_CMD_ID: id_cmd = val;
				default: ;
			endcase
		endfunction

		function bit is_frame_id(logic [7:0] b);
			return b == id_data || b == id_wb || b == id_cmd;
		endfunction

		// Error beat; the open frame's counters are dropped.
		function result_t abort_frame();
			result_t r;
			r = '0;
			r.event_kind = EV_ERROR;
			if (kind == FRAME_DATA) begin
				target = '0;
				rcvd = '0;
				partial = '0;
				running = 1'b0;
				r.aborted_kind = AB_DATA;
			end else if (kind == FRAME_WB) begin
				r.aborted_kind = AB_WB;
			end else begin
				cmd_cnt = '0;
				rs_hi = '0;
				rs_lo = '0;
				r.aborted_kind = AB_CMD;
			end
			kind = FRAME_IDLE;
			return r;
		endfunction

		function void note_byte(logic [7:0] b);
			result_t r;
			bit has;
			logic [15:0] grp;
			r = '0;
			has = 1'b0;
			grp = rcvd[17:2];
			case (kind)
				FRAME_IDLE: begin
					// data beats writeback beats command on equal IDs
					if (b == id_data) begin
						target = '0;
						rcvd = '0;
						partial = '0;
						running = 1'b0;
						phase = PH_HDR0;
						kind = FRAME_DATA;
					end else if (b == id_wb) begin
						phase = PH_HDR0;
						kind = FRAME_WB;
					end else if (b == id_cmd) begin
						cmd_cnt = '0;
						rs_hi = '0;
						rs_lo = '0;
						phase = PH_HDR0;
						kind = FRAME_CMD;
					end
				end
				FRAME_DATA: begin
					case (phase)
						PH_HDR0, PH_HDR1: begin
							if (b != 8'd0) begin
								r = abort_frame();
								has = 1'b1;
							end else begin
								phase = phase + 3'd1;
							end
						end
						PH_CNT_HI: begin
							target = {b, 8'h00};
							phase = PH_CNT_LO;
						end
						PH_CNT_LO: begin
							target[7:0] = b;
							phase = PH_BODY;
						end
						PH_BODY: begin
							// a zero count never gets past this test
							if (grp < target) begin
								if (rcvd[1:0] != 2'd3) begin
									partial = {partial[15:0], b};
								end else begin
									r.event_kind = EV_DATA;
									r.group_index = grp;
									r.first_half = partial[23:8];
									r.second_half = {partial[7:0], b};
									partial = '0;
									if ({1'b0, grp} + 17'd1 == {1'b0, target}) begin
										r.is_last = 1'b1;
										kind = FRAME_IDLE;
									end
									has = 1'b1;
								end
								rcvd = rcvd + 18'd1;
							end
						end
						default: begin
							r = abort_frame();
							has = 1'b1;
						end
					endcase
				end
				FRAME_WB: begin
					case (phase)
						PH_HDR0, PH_HDR1: begin
							if (b != 8'd0) begin
								r = abort_frame();
								has = 1'b1;
							end else begin
								phase = phase + 3'd1;
							end
						end
						PH_CNT_HI: begin
							phase = PH_CNT_LO;
							r.event_kind = EV_WB;
							r.group_index = grp;
							has = 1'b1;
						end
						PH_CNT_LO: kind = FRAME_IDLE;
						default: begin
							r = abort_frame();
							has = 1'b1;
						end
					endcase
				end
				default: begin
					if (cmd_cnt >= CMD_LEN_C) begin
						r = abort_frame();
					end else begin
						if (cmd_cnt == '0)
							rs_hi = b;
						else if (cmd_cnt == CMD_CNT_W'(1))
							rs_lo = b;
						r.event_kind = EV_CMD;
						r.cmd_index = 6'(cmd_cnt);
						r.cmd_byte = b;
						cmd_cnt = cmd_cnt + CMD_CNT_W'(1);
						if (cmd_cnt == CMD_LEN_C) begin
							r.is_last = 1'b1;
							r.resend_times = {rs_hi, rs_lo};
							kind = FRAME_IDLE;
							if (!running && grp != 16'd0) begin
								running = 1'b1;
								r.start_output = 1'b1;
							end
						end
					end
					has = 1'b1;
				end
			endcase
			if (has)
				pending_events.push_back(r);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				failed = 1'b1;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_events.size() == 0) begin
				$error("result beat with none pending: event_kind %0d", got.event_kind);
				failed = 1'b1;
				return;
			end
			want = pending_events.pop_front();
			compare_field("event_kind", 16'(want.event_kind), 16'(got.event_kind));
			compare_field("group_index", want.group_index, got.group_index);
			compare_field("first_half", want.first_half, got.first_half);
			compare_field("second_half", want.second_half, got.second_half);
			compare_field("is_last", 16'(want.is_last), 16'(got.is_last));
			compare_field("cmd_index", 16'(want.cmd_index), 16'(got.cmd_index));
			compare_field("cmd_byte", 16'(want.cmd_byte), 16'(got.cmd_byte));
			compare_field("resend_times", want.resend_times, got.resend_times);
			compare_field("start_output", 16'(want.start_output), 16'(got.start_output));
			compare_field("aborted_kind", 16'(want.aborted_kind), 16'(got.aborted_kind));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  event_kind;
	logic [15:0] group_index;
	logic [15:0] first_half;
	logic [15:0] second_half;
	logic        is_last;
	logic [5:0]  cmd_index;
	logic [7:0]  cmd_byte;
	logic [15:0] resend_times;
	logic        start_output;
	logic [1:0]  aborted_kind;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	result_t seen;
	frame_event_model sb;

	int n_sent;       // input beats accepted so far
	bit burst;        // current frame goes out back to back
	bit no_gap;       // sender never idles (long receiver hold-off)
	bit start_hold;   // kicks off the long receiver hold-off
	logic hold_off;
	int stall_left;   // cycles left in the receiver's current stall/no-stall run
	int stall_pick;
	bit stall_now;

	three_kind_frame_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.group_index  (group_index),
		.first_half   (first_half),
		.second_half  (second_half),
		.is_last      (is_last),
		.cmd_index    (cmd_index),
		.cmd_byte     (cmd_byte),
		.resend_times (resend_times),
		.start_output (start_output),
		.aborted_kind (aborted_kind),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// field order matches result_t
	assign seen = {event_kind, group_index, first_half, second_half, is_last,
		cmd_index, cmd_byte, resend_times, start_output, aborted_kind};

	always #5 clk = ~clk;

	// Result side. Values sampled at the edge are the pre-edge ones, so the
	// beat check and the stall update never race the DUT.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(seen);
		if (stall_left == 0) begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 60) begin
				stall_now = 1'b0;
				stall_left = $urandom_range(1, 20);
			end else if (stall_pick < 90) begin
				stall_now = 1'b1;
				stall_left = $urandom_range(1, 3);
			end else if (stall_pick < 98) begin
				stall_now = 1'b1;
				stall_left = $urandom_range(4, 15);
			end else begin
				stall_now = 1'b1;
				stall_left = $urandom_range(16, 40);
			end
		end
		stall_left--;
		out_stall <= hold_off || stall_now;
	end

	// One long receiver hold-off so the pipe fills and in_stall rises.
	initial begin
		hold_off = 1'b0;
		wait (start_hold);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Mostly short gaps, a few long ones.
	function automatic int pick_gap();
		int p;
		if (no_gap || burst)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_byte(b);
		n_sent++;
	endtask

	// Wait out every pending result, plus the bytes that make none.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_events.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// All three IDs in one burst of config beats; only call after drain().
	task automatic load_ids(input logic [7:0] d, input logic [7:0] w, input logic [7:0] c);
		logic [7:0] vals[3];
		logic [1:0] idxs[3];
		vals = '{d, w, c};
		idxs = '{CFG_DATA_ID, CFG_WB_ID, CFG_CMD_ID};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idxs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			sb.set_id(idxs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_data(input int count, input bit corrupt);
		send_byte(sb.id_data);
		if (corrupt) begin
			if ($urandom_range(0, 1))
				send_byte(8'h00);
			send_byte(8'($urandom_range(1, 255)));
			return;
		end
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'(count >> 8));
		send_byte(8'(count));
		repeat (count * 4) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_wb(input bit corrupt);
		send_byte(sb.id_wb);
		if (corrupt) begin
			if ($urandom_range(0, 1))
				send_byte(8'h00);
			send_byte(8'($urandom_range(1, 255)));
			return;
		end
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'($urandom_range(0, 255)));
		send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_cmd();
		send_byte(sb.id_cmd);
		repeat (CMD_LEN) send_byte(8'($urandom_range(0, 255)));
	endtask

	// Idle-state bytes that match no ID, so they are dropped.
	task automatic send_noise();
		logic [7:0] b;
		repeat ($urandom_range(1, 3)) begin
			do b = 8'($urandom_range(0, 255)); while (sb.is_frame_id(b));
			send_byte(b);
		end
	endtask

	task automatic random_frame();
		int p;
		int count;
		burst = ($urandom_range(0, 4) == 0);
		p = $urandom_range(0, 99);
		if (p < 45) begin
			count = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
			send_data(count, $urandom_range(0, 9) == 0);
		end else if (p < 65) begin
			send_wb($urandom_range(0, 6) == 0);
		end else if (p < 90) begin
			send_cmd();
		end else begin
			send_noise();
		end
		burst = 1'b0;
	endtask

	// Stimulus
	initial begin
		logic [7:0] d;
		logic [7:0] w;
		logic [7:0] c;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DATA_ID;
		cfg_data = 8'h00;
		n_sent = 0;
		burst = 1'b0;
		no_gap = 1'b0;
		start_hold = 1'b0;
		stall_left = 0;
		stall_now = 1'b0;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: dropped byte, writeback before any data (zero groups),
		// one all-ones/all-zeros group, command that starts output, data
		// header error.
		send_byte(8'hFF);
		send_wb(1'b0);
		send_byte(sb.id_data);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h00);
		send_cmd();
		send_byte(sb.id_data);
		send_byte(8'h7F);

		// Random traffic on the reset IDs.
		while (n_sent < 200) random_frame();
		drain();

		// IDs at the extremes.
		load_ids(8'h00, 8'hFF, 8'h80);
		while (n_sent < 380) random_frame();
		drain();

		// Equal IDs: data wins over the other two.
		load_ids(8'h5A, 8'h5A, 8'h5A);
		send_data(1, 1'b0);
		drain();
		// writeback wins over command
		load_ids(8'h11, 8'h22, 8'h22);
		send_wb(1'b0);
		drain();

		// Random distinct IDs.
		do begin
			d = 8'($urandom_range(0, 255));
			w = 8'($urandom_range(0, 255));
			c = 8'($urandom_range(0, 255));
		end while (d == w || d == c || w == c);
		load_ids(d, w, c);

		// Receiver holds off while the sender keeps pushing command bytes.
		no_gap = 1'b1;
		start_hold = 1'b1;
		repeat (6) send_cmd();
		no_gap = 1'b0;
		while (n_sent < 650) random_frame();

		// Zero-count data frame: everything after it is swallowed, ID bytes
		// included, so it has to come last.
		send_byte(sb.id_data);
		repeat (4) send_byte(8'h00);
		send_byte(sb.id_wb);
		send_byte(sb.id_cmd);
		repeat (4) send_byte(8'($urandom_range(0, 255)));
		drain();
		repeat (10) @(posedge clk);

		if (!sb.failed)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Run limit, far past the slowest legal run.
	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tkfp_pkg.sv
rtl/three_kind_frame_parser.sv
rtl/tkfp_checker.sv
tb/three_kind_frame_parser_tb.sv
